@@ rtl/ptd_pkg.sv @@
// Package for the periodic task dispatcher: command and slot state codes,
// and the command and status structs between controller and datapath.
// No dependencies.
package ptd_pkg;

  localparam logic [2:0] FN_TIMER  = 3'd0;
  localparam logic [2:0] FN_CREATE = 3'd1;
  localparam logic [2:0] FN_PAUSE  = 3'd2;
  localparam logic [2:0] FN_RESUME = 3'd3;
  localparam logic [2:0] FN_DELETE = 3'd4;

  localparam logic [1:0] ST_READY  = 2'd0;
  localparam logic [1:0] ST_PAUSED = 2'd1;
  localparam logic [1:0] ST_KILLED = 2'd2;

  localparam int unsigned TICK_W = 32;
  localparam int unsigned PER_W  = 16;
  localparam int unsigned CNT_W  = 5;

  typedef struct packed {
    logic accept;
    logic scan_init;
    logic scan_dec;
    logic div_start;
    logic div_step;
    logic set_pending;
    logic push;
    logic push_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic tick_fires;
    logic slot_elig;
    logic div_last;
    logic is_due;
    logic pending_valid;
    logic out_free;
    logic scan_zero;
  } dp_status_t;

endpackage

@@ rtl/ptd_ctrl.sv @@
// Controller of the periodic task dispatcher: sequences the slot scan, the
// serial modulo and the result hand-off. Depends on ptd_pkg.
module ptd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ptd_pkg::dp_status_t status_i,
  output ptd_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SLOT,
    S_DIV,
    S_TEST,
    S_PUSH,
    S_NEXT,
    S_FLUSH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.tick_fires) begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SLOT;
          end
        end
      end
      S_SLOT: begin
        if (status_i.slot_elig) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_TEST;
        end
      end
      S_TEST: begin
        priority if (!status_i.is_due) begin
          state_d = S_NEXT;
        end else if (status_i.pending_valid) begin
          state_d = S_PUSH;
        end else begin
          cmd_o.set_pending = 1'b1;
          state_d           = S_NEXT;
        end
      end
      S_PUSH: begin
        if (status_i.out_free) begin
          cmd_o.push        = 1'b1;
          cmd_o.set_pending = 1'b1;
          state_d           = S_NEXT;
        end
      end
      S_NEXT: begin
        if (status_i.scan_zero) begin
          state_d = S_FLUSH;
        end else begin
          cmd_o.scan_dec = 1'b1;
          state_d        = S_SLOT;
        end
      end
      S_FLUSH: begin
        if (!status_i.pending_valid) begin
          state_d = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_last = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

@@ rtl/ptd_dp.sv @@
// Datapath of the periodic task dispatcher: slot table, prescaler, tick
// counter, serial 32-by-16 modulo and result register. Depends on ptd_pkg.
module ptd_dp #(
  parameter int unsigned NUM_TASKS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic [2:0]          func_i,
  input  logic [2:0]          task_index_i,
  input  logic                has_handler_i,
  input  logic [1:0]          initial_state_i,
  input  logic [15:0]         period_i,
  input  logic [7:0]          phase_i,
  input  ptd_pkg::ctrl_cmd_t  cmd_i,
  output ptd_pkg::dp_status_t status_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          due_task_o,
  output logic [31:0]         tick_value_o,
  output logic                last_o
);

  localparam int unsigned SW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam logic [SW-1:0] TopSlot = SW'(NUM_TASKS - 1);
  localparam logic [ptd_pkg::CNT_W-1:0] LastStep = ptd_pkg::CNT_W'(ptd_pkg::TICK_W - 1);

  logic [NUM_TASKS-1:0] slot_valid_q, slot_valid_d;
  logic [1:0]           slot_state_q  [NUM_TASKS];
  logic [15:0]          slot_period_q [NUM_TASKS];
  logic [7:0]           slot_phase_q  [NUM_TASKS];

  logic [7:0]  events_q;
  logic [7:0]  prescale_q, prescale_d;
  logic [31:0] tick_q, tick_d;

  logic [SW-1:0] scan_q, pend_idx_q;
  logic          pend_valid_q;

  logic [15:0] rem_q;
  logic [31:0] dvd_q;
  logic [ptd_pkg::CNT_W-1:0] cnt_q;
  logic [16:0] shifted;
  logic [16:0] diff;

  logic        out_valid_q;
  logic [2:0]  out_task_q;
  logic [31:0] out_tick_q;
  logic        out_last_q;

  logic          cmd_hit;
  logic [SW-1:0] wr_idx;
  logic          fires;

  assign wr_idx  = SW'(task_index_i);
  assign cmd_hit = cmd_i.accept && (32'(task_index_i) < NUM_TASKS);
  assign fires   = (func_i == ptd_pkg::FN_TIMER) && (prescale_q == 8'd1);

  always_comb begin
    slot_valid_d = slot_valid_q;
    if (cmd_hit && (func_i == ptd_pkg::FN_CREATE) && has_handler_i) begin
      slot_valid_d[wr_idx] = 1'b1;
    end
  end

  always_comb begin
    prescale_d = prescale_q;
    tick_d     = tick_q;
    if (cmd_i.accept && (func_i == ptd_pkg::FN_TIMER)) begin
      if (fires) begin
        prescale_d = events_q;
        tick_d     = tick_q + 32'd1;
      end else begin
        prescale_d = prescale_q - 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      events_q     <= 8'd1;
      prescale_q   <= 8'd1;
      tick_q       <= '0;
    end else begin
      slot_valid_q <= slot_valid_d;
      prescale_q   <= prescale_d;
      tick_q       <= tick_d;
      if (cfg_we_i) begin
        events_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_hit) begin
      unique case (func_i)
        ptd_pkg::FN_CREATE: begin
          if (has_handler_i) begin
            slot_state_q[wr_idx]  <= initial_state_i;
            slot_period_q[wr_idx] <= period_i;
            slot_phase_q[wr_idx]  <= phase_i;
          end
        end
        ptd_pkg::FN_PAUSE:  slot_state_q[wr_idx] <= ptd_pkg::ST_PAUSED;
        ptd_pkg::FN_RESUME: slot_state_q[wr_idx] <= ptd_pkg::ST_READY;
        ptd_pkg::FN_DELETE: slot_state_q[wr_idx] <= ptd_pkg::ST_KILLED;
        default: begin
        end
      endcase
    end
  end

  // One restoring division step per cycle; only the remainder is kept.
  assign shifted = {rem_q, dvd_q[31]};
  assign diff    = shifted - {1'b0, slot_period_q[scan_q]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      scan_q <= TopSlot;
    end else if (cmd_i.scan_dec) begin
      scan_q <= scan_q - SW'(1);
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      dvd_q <= tick_q;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= diff[16] ? shifted[15:0] : diff[15:0];
      dvd_q <= {dvd_q[30:0], 1'b0};
      cnt_q <= cnt_q + ptd_pkg::CNT_W'(1);
    end
    if (cmd_i.set_pending) begin
      pend_idx_q <= scan_q;
    end
    if (cmd_i.push) begin
      out_task_q <= 3'(pend_idx_q);
      out_tick_q <= tick_q;
      out_last_q <= cmd_i.push_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      priority if (cmd_i.scan_init) begin
        pend_valid_q <= 1'b0;
      end else if (cmd_i.set_pending) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.push) begin
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    status_o               = '0;
    status_o.tick_fires    = fires;
    status_o.slot_elig     = slot_valid_q[scan_q]
                             && (slot_state_q[scan_q] == ptd_pkg::ST_READY)
                             && (slot_period_q[scan_q] != 16'd0);
    status_o.div_last      = (cnt_q == LastStep);
    status_o.is_due        = (rem_q == {8'd0, slot_phase_q[scan_q]});
    status_o.pending_valid = pend_valid_q;
    status_o.out_free      = !out_valid_q || !out_stall_i;
    status_o.scan_zero     = (scan_q == '0);
  end

  assign out_valid_o  = out_valid_q;
  assign due_task_o   = out_task_q;
  assign tick_value_o = out_tick_q;
  assign last_o       = out_last_q;

endmodule

@@ rtl/periodic_task_dispatcher_top.sv @@
// Top level of the periodic task dispatcher: joins the controller and the
// datapath. Depends on ptd_pkg, ptd_ctrl and ptd_dp.
//
// The input channel carries one command per transaction: a timer event or a
// create, pause, resume or delete of a task slot. A timer event that ends a
// prescale period advances the tick counter and starts a scan of all slots
// from the highest index down; each due task yields one output transaction
// with its index and the tick count, and the final one of the tick has last
// set. Task commands and timer events that do not end a period are taken
// without a scan. A scan runs the serial modulo on each ready slot with a
// nonzero period. The input is stalled while a scan runs. If the receiver
// stalls, the scan waits with one result held in the output register and
// one pending. The user must write the configuration register with
// cfg_we_i only while the block is idle; the block does not enforce this.
// A write takes effect at the next reload. Reset empties the task table,
// clears the tick counter and sets the prescaler and register to one.
module periodic_task_dispatcher_top #(
  parameter int unsigned NUM_TASKS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [2:0]  task_index_i,
  input  logic        has_handler_i,
  input  logic [1:0]  initial_state_i,
  input  logic [15:0] period_i,
  input  logic [7:0]  phase_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  due_task_o,
  output logic [31:0] tick_value_o,
  output logic        last_o
);

  ptd_pkg::ctrl_cmd_t  cmd;
  ptd_pkg::dp_status_t status;

  ptd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ptd_dp #(
    .NUM_TASKS (NUM_TASKS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .func_i          (func_i),
    .task_index_i    (task_index_i),
    .has_handler_i   (has_handler_i),
    .initial_state_i (initial_state_i),
    .period_i        (period_i),
    .phase_i         (phase_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .due_task_o      (due_task_o),
    .tick_value_o    (tick_value_o),
    .last_o          (last_o)
  );

endmodule

@@ verif/ptd_dispatch_check.sv @@
// Scoreboard for the periodic task dispatcher: tracks the task table, the
// prescaler and the tick count from observed transactions and compares each
// dispatch against the oldest predicted one. Depends on ptd_pkg.
module ptd_dispatch_check #(
  parameter int unsigned NUM_TASKS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [2:0]        func_i,
  input  logic [2:0]        task_index_i,
  input  logic              has_handler_i,
  input  logic [1:0]        initial_state_i,
  input  logic [15:0]       period_i,
  input  logic [7:0]        phase_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [2:0]        due_task_i,
  input  logic [31:0]       tick_value_i,
  input  logic              last_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       pending_o
);

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [2:0]                    due_task;
    logic [ptd_pkg::TICK_W-1:0]    tick_value;
    logic                          last;
  } dispatch_t;

  dispatch_t                     due_queue[$];
  dispatch_t                     oldest_due;
  logic                          slot_valid  [NUM_TASKS];
  logic [1:0]                    slot_state  [NUM_TASKS];
  logic [ptd_pkg::PER_W-1:0]     slot_period [NUM_TASKS];
  logic [7:0]                    slot_phase  [NUM_TASKS];
  logic [7:0]                    events_per_tick;
  logic [7:0]                    prescale_left;
  logic [ptd_pkg::TICK_W-1:0]    tick_count;
  logic [NUM_TASKS-1:0]          due_mask;
  int unsigned                   due_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_TASKS; s++) begin
        slot_valid[s]  = 1'b0;
        slot_state[s]  = ptd_pkg::ST_READY;
        slot_period[s] = '0;
        slot_phase[s]  = '0;
      end
      events_per_tick  = 8'd1;
      prescale_left    = 8'd1;
      tick_count       = '0;
      due_queue.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_queue.size() == 0) begin
          if (mismatch_count_o < REPORT_LIMIT) begin
            $display("unexpected dispatch: task %0d tick %0d last %0d",
                     due_task_i, tick_value_i, last_i);
          end
          mismatch_count_o++;
        end else begin
          oldest_due = due_queue.pop_front();
          if (oldest_due.due_task !== due_task_i || oldest_due.tick_value !== tick_value_i ||
              oldest_due.last !== last_i) begin
            if (mismatch_count_o < REPORT_LIMIT) begin
              $display({"dispatch mismatch: expected task %0d tick %0d last %0d, ",
                        "got task %0d tick %0d last %0d"},
                       oldest_due.due_task, oldest_due.tick_value, oldest_due.last,
                       due_task_i, tick_value_i, last_i);
            end
            mismatch_count_o++;
          end
        end
      end

      if (cfg_we_i) begin
        events_per_tick = cfg_wdata_i;
      end

      if (in_valid_i && !in_stall_i) begin
        if (func_i == ptd_pkg::FN_TIMER) begin
          prescale_left = prescale_left - 8'd1;
          if (prescale_left == 8'd0) begin
            prescale_left = events_per_tick;
            tick_count    = tick_count + 1;
            due_left      = 0;
            for (int s = 0; s < NUM_TASKS; s++) begin
              due_mask[s] = slot_valid[s] && slot_state[s] == ptd_pkg::ST_READY &&
                            slot_period[s] != '0 &&
                            (tick_count % 32'(slot_period[s])) == 32'(slot_phase[s]);
              due_left += due_mask[s];
            end
            for (int s = NUM_TASKS - 1; s >= 0; s--) begin
              if (due_mask[s]) begin
                due_left--;
                due_queue.push_back(dispatch_t'{due_task: 3'(s), tick_value: tick_count,
                                                last: due_left == 0});
              end
            end
          end
        end else if (32'(task_index_i) < NUM_TASKS) begin
          case (func_i)
            ptd_pkg::FN_CREATE: begin
              if (has_handler_i) begin
                slot_valid[task_index_i]  = 1'b1;
                slot_state[task_index_i]  = initial_state_i;
                slot_period[task_index_i] = period_i;
                slot_phase[task_index_i]  = phase_i;
              end
            end
            ptd_pkg::FN_PAUSE:  slot_state[task_index_i] = ptd_pkg::ST_PAUSED;
            ptd_pkg::FN_RESUME: slot_state[task_index_i] = ptd_pkg::ST_READY;
            ptd_pkg::FN_DELETE: slot_state[task_index_i] = ptd_pkg::ST_KILLED;
            default: begin
            end
          endcase
        end
      end

      pending_o = due_queue.size();
    end
  end

endmodule

@@ verif/periodic_task_dispatcher_top_tb.sv @@
// Testbench top for the periodic task dispatcher: drives directed and random
// commands, timer floods and prescale settings under varied idling, and gives
// the verdict. Depends on ptd_pkg, periodic_task_dispatcher_top and ptd_dispatch_check.
module periodic_task_dispatcher_top_tb;

  localparam int unsigned NUM_TASKS        = 8;
  localparam int unsigned SETTLE_CYCLES    = 400;
  localparam int unsigned CYCLE_LIMIT      = 500000;
  localparam int unsigned RANDOM_PER_PHASE = 24;
  localparam int unsigned FLOOD_EVENTS     = 4;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [7:0]  cfg_wdata_i     = '0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [2:0]  func_i          = '0;
  logic [2:0]  task_index_i    = '0;
  logic        has_handler_i   = 1'b0;
  logic [1:0]  initial_state_i = '0;
  logic [15:0] period_i        = '0;
  logic [7:0]  phase_i         = '0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [2:0]  due_task_o;
  logic [31:0] tick_value_o;
  logic        last_o;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  int unsigned mismatch_count;
  int unsigned pending_count;

  periodic_task_dispatcher_top #(
    .NUM_TASKS(NUM_TASKS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .task_index_i   (task_index_i),
    .has_handler_i  (has_handler_i),
    .initial_state_i(initial_state_i),
    .period_i       (period_i),
    .phase_i        (phase_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .due_task_o     (due_task_o),
    .tick_value_o   (tick_value_o),
    .last_o         (last_o)
  );

  ptd_dispatch_check #(
    .NUM_TASKS(NUM_TASKS)
  ) dispatch_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .func_i          (func_i),
    .task_index_i    (task_index_i),
    .has_handler_i   (has_handler_i),
    .initial_state_i (initial_state_i),
    .period_i        (period_i),
    .phase_i         (phase_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .due_task_i      (due_task_o),
    .tick_value_i    (tick_value_o),
    .last_i          (last_o),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_count)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("periodic_task_dispatcher_top_tb: errors");
      $finish;
    end
  end

  task automatic send_cmd(input logic [2:0] func, input logic [2:0] slot,
                          input logic handler, input logic [1:0] state,
                          input logic [15:0] period, input logic [7:0] phase);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    func_i          = func;
    task_index_i    = slot;
    has_handler_i   = handler;
    initial_state_i = state;
    period_i        = period;
    phase_i         = phase;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  task automatic set_prescale(input logic [7:0] events);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = events;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_random_cmd();
    int unsigned pick;
    logic [2:0]  func;
    logic [1:0]  state;
    logic [15:0] period;
    logic [7:0]  phase;
    pick = $urandom_range(99);
    if (pick < 45) func = ptd_pkg::FN_TIMER;
    else if (pick < 70) func = ptd_pkg::FN_CREATE;
    else if (pick < 78) func = ptd_pkg::FN_PAUSE;
    else if (pick < 86) func = ptd_pkg::FN_RESUME;
    else if (pick < 94) func = ptd_pkg::FN_DELETE;
    else func = 3'($urandom_range(7, ptd_pkg::FN_DELETE + 1));
    state = ($urandom_range(99) < 70) ? ptd_pkg::ST_READY : 2'($urandom);
    pick = $urandom_range(99);
    if (pick < 10) period = '0;
    else if (pick < 85) period = 16'($urandom_range(12, 1));
    else period = 16'($urandom);
    if (period != '0 && period <= 16'd12 && $urandom_range(99) < 80) begin
      phase = 8'($urandom_range(period - 1, 0));
    end else begin
      phase = 8'($urandom);
    end
    send_cmd(func, 3'($urandom), $urandom_range(9) != 0, state, period, phase);
  endtask

  task automatic send_timer_flood(input int unsigned count);
    repeat (count) begin
      send_cmd(ptd_pkg::FN_TIMER, 3'($urandom), 1'($urandom), 2'($urandom), 16'($urandom),
               8'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    set_prescale(8'd1);

    send_cmd(ptd_pkg::FN_CREATE, 3'd7, 1'b1, ptd_pkg::ST_READY, 16'd1, 8'd0);
    send_cmd(ptd_pkg::FN_CREATE, 3'd0, 1'b1, ptd_pkg::ST_READY, 16'hFFFF, 8'hFF);
    send_cmd(ptd_pkg::FN_CREATE, 3'd3, 1'b0, ptd_pkg::ST_READY, 16'd2, 8'd0);
    send_cmd(ptd_pkg::FN_CREATE, 3'd5, 1'b1, ptd_pkg::ST_READY, 16'd0, 8'd0);
    send_cmd(ptd_pkg::FN_CREATE, 3'd2, 1'b1, 2'd3, 16'd1, 8'd0);
    send_cmd(ptd_pkg::FN_CREATE, 3'd4, 1'b1, ptd_pkg::ST_READY, 16'd3, 8'd1);
    send_cmd(ptd_pkg::FN_TIMER, 3'd0, 1'b0, ptd_pkg::ST_READY, 16'd0, 8'd0);
    send_cmd(ptd_pkg::FN_TIMER, 3'd7, 1'b1, ptd_pkg::ST_KILLED, 16'hFFFF, 8'hFF);
    send_cmd(ptd_pkg::FN_PAUSE, 3'd7, 1'b0, ptd_pkg::ST_READY, 16'd0, 8'd0);
    send_cmd(ptd_pkg::FN_TIMER, 3'd0, 1'b0, ptd_pkg::ST_READY, 16'd0, 8'd0);
    send_cmd(ptd_pkg::FN_RESUME, 3'd7, 1'b0, ptd_pkg::ST_READY, 16'd0, 8'd0);
    send_cmd(ptd_pkg::FN_DELETE, 3'd4, 1'b0, ptd_pkg::ST_READY, 16'd0, 8'd0);
    send_cmd(ptd_pkg::FN_TIMER, 3'd0, 1'b0, ptd_pkg::ST_READY, 16'd0, 8'd0);
    send_cmd(ptd_pkg::FN_RESUME, 3'd4, 1'b0, ptd_pkg::ST_READY, 16'd0, 8'd0);
    send_cmd(ptd_pkg::FN_PAUSE, 3'd6, 1'b0, ptd_pkg::ST_READY, 16'd0, 8'd0);
    send_cmd(ptd_pkg::FN_RESUME, 3'd6, 1'b0, ptd_pkg::ST_READY, 16'd0, 8'd0);
    send_cmd(ptd_pkg::FN_DELETE, 3'd3, 1'b0, ptd_pkg::ST_READY, 16'd0, 8'd0);
    send_cmd(ptd_pkg::FN_TIMER, 3'd0, 1'b0, ptd_pkg::ST_READY, 16'd0, 8'd0);
    send_cmd(3'(ptd_pkg::FN_DELETE + 1), 3'd7, 1'b1, ptd_pkg::ST_READY, 16'd1, 8'd0);
    send_cmd(3'(ptd_pkg::FN_DELETE + 2), 3'd1, 1'b1, ptd_pkg::ST_READY, 16'd1, 8'd0);
    send_cmd(3'(ptd_pkg::FN_DELETE + 3), 3'd6, 1'b1, ptd_pkg::ST_READY, 16'd1, 8'd0);
    send_cmd(ptd_pkg::FN_CREATE, 3'd1, 1'b1, ptd_pkg::ST_READY, 16'd2, 8'd1);
    send_cmd(ptd_pkg::FN_CREATE, 3'd6, 1'b1, ptd_pkg::ST_READY, 16'd1, 8'd0);
    send_cmd(ptd_pkg::FN_TIMER, 3'd0, 1'b0, ptd_pkg::ST_READY, 16'd0, 8'd0);
    send_cmd(ptd_pkg::FN_TIMER, 3'd0, 1'b0, ptd_pkg::ST_READY, 16'd0, 8'd0);

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin
          set_prescale(8'd2);
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          set_prescale(8'd1);
          send_idle_pct  = 63;
          recv_stall_pct = 0;
        end
        2: begin
          set_prescale(8'd3);
          send_idle_pct  = 0;
          recv_stall_pct = 63;
        end
        default: begin
          set_prescale(8'd1);
          send_idle_pct  = 16;
          recv_stall_pct = 16;
        end
      endcase
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (mode == 1 && i == RANDOM_PER_PHASE / 2) wait_drained();
        send_random_cmd();
      end
    end

    set_prescale(8'd0);
    send_cmd(ptd_pkg::FN_CREATE, 3'd7, 1'b1, ptd_pkg::ST_READY, 16'd1, 8'd0);
    send_timer_flood(FLOOD_EVENTS);
    set_prescale(8'd255);
    send_timer_flood(FLOOD_EVENTS);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("periodic_task_dispatcher_top_tb: clean");
    end else begin
      $display("periodic_task_dispatcher_top_tb: errors");
    end
    $finish;
  end

endmodule
